[rtl/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, widths, the log2 table and the leading-one and saturation
// helpers for the separative work calculator.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int QTY_W     = 32;
  localparam int ASSAY_W   = 24;
  localparam int RES_W     = 48;
  localparam int DATA_IN_W = QTY_W + 3 * ASSAY_W;
  localparam int DATA_OUT_W = 3 * RES_W;

  localparam int LOG_TABLE_BITS = 8;
  localparam int TBL_N   = (1 << LOG_TABLE_BITS) + 1;
  localparam int TBL_W   = 29;
  localparam int IDX_W   = LOG_TABLE_BITS + 1;
  localparam int FRAC_Q  = 28;
  localparam int NORM_W  = 32;
  localparam int FRAC_W  = NORM_W - 1 - LOG_TABLE_BITS;
  localparam int DIF_W   = TBL_W - LOG_TABLE_BITS;
  localparam int LEAD_W  = 5;
  localparam int LOG_W   = 33;
  localparam int V_W     = LOG_W + 1;
  localparam int LN2_W   = 28;
  localparam logic [LN2_W-1:0] LN2_Q28 = 28'hB17217F;
  localparam int W_W     = ASSAY_W + 2;
  localparam int LNP_W   = V_W + LN2_W + 1;
  localparam int VP_W    = V_W + W_W;

  localparam int NUM_MAG_W = 58;
  localparam int NUM_W     = NUM_MAG_W + 1;
  localparam int DEN_W     = ASSAY_W;
  localparam int DIV_LAT   = NUM_MAG_W + 1;

  localparam int LO_W    = 32;
  localparam int PP0_W   = LO_W + QTY_W;
  localparam int PP1_W   = NUM_MAG_W - LO_W + QTY_W;
  localparam int PROD_W  = PP1_W + LO_W;
  localparam int SH_W    = PROD_W - FRAC_Q;

  localparam int VALUE_LAT   = 6;
  localparam int DIV_IN_STG  = VALUE_LAT + 2;
  localparam int DIV_OUT_STG = DIV_IN_STG + DIV_LAT;
  localparam int PIPE_LAST   = DIV_OUT_STG + 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_ZERO_ASSAY = 2'd1,
    ERR_FEED_TAILS = 2'd2
  } err_e;

  typedef struct packed {
    logic [QTY_W-1:0]   product_mass;
    logic [ASSAY_W-1:0] feed_assay;
    logic [ASSAY_W-1:0] product_assay;
    logic [ASSAY_W-1:0] tails_assay;
    err_e               err;
  } item_t;

  typedef struct packed {
    item_t                 item;
    logic signed [V_W-1:0] vp;
  } ctx_t;

  typedef logic [TBL_W-1:0] log_tbl_t [TBL_N];

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t          t;
    longint unsigned   y;
    logic [TBL_W-1:0]  v;
    for (int i = 0; i < TBL_N - 1; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      v = '0;
      for (int k = 0; k < FRAC_Q; k++) begin
        y = (y * y) >> 30;
        v = {v[TBL_W-2:0], 1'b0};
        if (y >= (64'd1 << 31)) begin
          v[0] = 1'b1;
          y = y >> 1;
        end
      end
      t[i] = v;
    end
    t[TBL_N-1] = TBL_W'(1) << FRAC_Q;
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();

  function automatic logic [LEAD_W-1:0] lead_one(input logic [ASSAY_W-1:0] n);
    logic [LEAD_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < ASSAY_W; i++) begin
      if (n[i]) pos = LEAD_W'(i);
    end
    return pos;
  endfunction

  function automatic logic signed [RES_W-1:0] sat48(input logic signed [NUM_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > NUM_W'(RES_MAX)) r = RES_MAX;
    else if (v < NUM_W'(RES_MIN)) r = RES_MIN;
    else r = v[RES_W-1:0];
    return r;
  endfunction

endpackage

[rtl/separative_work_calculator_top.sv]
// ----------------------------------------------------------------------------
// separative_work_calculator_top
// Feed mass, tails mass and separative work from product quantity and
// feed, product and tails assays.
//
//   Channel  Dir  Handshake              tdata / tuser
//   s_axis   in   tvalid/tready          tdata[103:0] qty, feed, product, tails
//   m_axis   out  tvalid/tready          tdata[143:0] feed, tails, work; tuser err
//
// One word per cycle sustained while the output is not stalled. Most of the
// depth lies in the 58-stage quotient pipelines. A 4-word queue keeps
// s_axis_tready_o high while the output is stalled, until the queue fills.
// The whole back pipeline holds while the output word waits. Reset is
// asynchronous, active low, and clears only valid bits and queue pointers.
// ----------------------------------------------------------------------------
module separative_work_calculator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // product_mass[31:0], feed_assay[55:32], product_assay[79:56], tails_assay[103:80]
  input  logic [swc_pkg::DATA_IN_W-1:0]      s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // feed_mass[47:0], tails_mass[95:48], separative_work[143:96]
  output logic [swc_pkg::DATA_OUT_W-1:0]     m_axis_tdata_o,
  // error_code[1:0]
  output logic [1:0]                         m_axis_tuser_o
);

  localparam int QW = swc_pkg::QTY_W;
  localparam int AW = swc_pkg::ASSAY_W;

  logic                             q_valid, q_pop;
  swc_pkg::item_t                   q_item;
  logic signed [swc_pkg::RES_W-1:0] feed_mass, tails_mass, sep_work;
  swc_pkg::err_e                    err;

  swc_front u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i      (s_axis_tvalid_i),
    .s_tready_o      (s_axis_tready_o),
    .product_mass_i  (s_axis_tdata_i[QW-1:0]),
    .feed_assay_i    (s_axis_tdata_i[QW+AW-1:QW]),
    .product_assay_i (s_axis_tdata_i[QW+2*AW-1:QW+AW]),
    .tails_assay_i   (s_axis_tdata_i[QW+3*AW-1:QW+2*AW]),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  swc_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .feed_mass_o  (feed_mass),
    .tails_mass_o (tails_mass),
    .sep_work_o   (sep_work),
    .err_o        (err)
  );

  assign m_axis_tdata_o = {sep_work, tails_mass, feed_mass};
  assign m_axis_tuser_o = err;

endmodule

[rtl/swc_front.sv]
// ----------------------------------------------------------------------------
// swc_front
// Input side: classifies each word by its error code and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
module swc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [swc_pkg::QTY_W-1:0]     product_mass_i,
  input  logic [swc_pkg::ASSAY_W-1:0]   feed_assay_i,
  input  logic [swc_pkg::ASSAY_W-1:0]   product_assay_i,
  input  logic [swc_pkg::ASSAY_W-1:0]   tails_assay_i,
  output logic                          q_valid_o,
  output swc_pkg::item_t                q_item_o,
  input  logic                          q_pop_i
);

  swc_pkg::item_t              mem_q [swc_pkg::QUEUE_DEPTH];
  swc_pkg::item_t              item_in;
  logic [swc_pkg::QP_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [swc_pkg::QP_W:0]      cnt_q, cnt_d;
  logic                        push;

  always_comb begin
    item_in.product_mass  = product_mass_i;
    item_in.feed_assay    = feed_assay_i;
    item_in.product_assay = product_assay_i;
    item_in.tails_assay   = tails_assay_i;
    priority if (feed_assay_i == '0 || product_assay_i == '0 || tails_assay_i == '0) begin
      item_in.err = swc_pkg::ERR_ZERO_ASSAY;
    end else if (feed_assay_i == tails_assay_i) begin
      item_in.err = swc_pkg::ERR_FEED_TAILS;
    end else begin
      item_in.err = swc_pkg::ERR_OK;
    end
  end

  assign s_tready_o = (cnt_q != (swc_pkg::QP_W+1)'(swc_pkg::QUEUE_DEPTH));
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == swc_pkg::QP_W'(swc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == swc_pkg::QP_W'(swc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (swc_pkg::QP_W+1)'(push) - (swc_pkg::QP_W+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/swc_value.sv]
// ----------------------------------------------------------------------------
// swc_value
// Six-stage pipeline for V(x) = (1-2x) ln((1-x)/x) in Q.28, using a
// leading-one normalize, table lookup and linear interpolation of log2.
// ----------------------------------------------------------------------------
module swc_value (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [swc_pkg::ASSAY_W-1:0]        x_i,
  output logic signed [swc_pkg::V_W-1:0]     v_o
);

  logic [swc_pkg::ASSAY_W-1:0]   x_q   [5];
  logic [swc_pkg::ASSAY_W-1:0]   n_in  [2];
  logic [swc_pkg::ASSAY_W-1:0]   n1_q  [2];
  logic [swc_pkg::LEAD_W-1:0]    e1_q  [2];
  logic [swc_pkg::LEAD_W-1:0]    e2_q  [2];
  logic [swc_pkg::TBL_W-1:0]     lo2_q [2];
  logic [swc_pkg::DIF_W-1:0]     dd2_q [2];
  logic [swc_pkg::FRAC_W-1:0]    r2_q  [2];
  logic [swc_pkg::LOG_W-1:0]     lg3_q [2];
  logic signed [swc_pkg::V_W-1:0]   dl4_q, ln5_q, v_q;
  logic signed [swc_pkg::LNP_W-1:0] lnp;
  logic signed [swc_pkg::W_W-1:0]   w;
  logic signed [swc_pkg::VP_W-1:0]  vp;

  assign n_in[0] = swc_pkg::ASSAY_W'((swc_pkg::ASSAY_W+1)'(1) << swc_pkg::ASSAY_W) - x_i;
  assign n_in[1] = x_i;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [swc_pkg::NORM_W-1:0]          m;
    logic [swc_pkg::LOG_TABLE_BITS-1:0]  idx;
    logic [swc_pkg::TBL_W-1:0]           lo, hi;
    logic [swc_pkg::DIF_W+swc_pkg::FRAC_W-1:0] prod;

    assign m    = swc_pkg::NORM_W'(n1_q[l]) << (swc_pkg::LEAD_W'(swc_pkg::NORM_W - 1) - e1_q[l]);
    assign idx  = m[swc_pkg::NORM_W-2 -: swc_pkg::LOG_TABLE_BITS];
    assign lo   = swc_pkg::LOG_TBL[{1'b0, idx}];
    assign hi   = swc_pkg::LOG_TBL[{1'b0, idx} + swc_pkg::IDX_W'(1)];
    assign prod = dd2_q[l] * r2_q[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n1_q[l]  <= n_in[l];
        e1_q[l]  <= swc_pkg::lead_one(n_in[l]);
        e2_q[l]  <= e1_q[l];
        lo2_q[l] <= lo;
        dd2_q[l] <= (hi > lo) ? swc_pkg::DIF_W'(hi - lo) : '0;
        r2_q[l]  <= m[swc_pkg::FRAC_W-1:0];
        lg3_q[l] <= (swc_pkg::LOG_W'(e2_q[l]) << swc_pkg::FRAC_Q) + swc_pkg::LOG_W'(lo2_q[l])
                  + swc_pkg::LOG_W'(prod[swc_pkg::DIF_W+swc_pkg::FRAC_W-1:swc_pkg::FRAC_W]);
      end
    end
  end

  assign lnp = dl4_q * $signed({1'b0, swc_pkg::LN2_Q28});
  assign w   = $signed({2'b01, {swc_pkg::ASSAY_W{1'b0}}}) - $signed({1'b0, x_q[4], 1'b0});
  assign vp  = w * ln5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x_i;
      for (int i = 1; i < 5; i++) x_q[i] <= x_q[i-1];
      dl4_q <= $signed({1'b0, lg3_q[0]}) - $signed({1'b0, lg3_q[1]});
      ln5_q <= swc_pkg::V_W'(lnp >>> swc_pkg::FRAC_Q);
      v_q   <= swc_pkg::V_W'(vp >>> swc_pkg::ASSAY_W);
    end
  end

  assign v_o = v_q;

endmodule

[rtl/swc_div.sv]
// ----------------------------------------------------------------------------
// swc_div
// Pipelined signed divider, one quotient bit per stage, quotient truncated
// toward zero.
// ----------------------------------------------------------------------------
module swc_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [swc_pkg::NUM_W-1:0]    num_i,
  input  logic signed [swc_pkg::DEN_W:0]      den_i,
  output logic signed [swc_pkg::NUM_W-1:0]    quo_o
);

  localparam int LAST = swc_pkg::NUM_MAG_W - 1;

  logic [swc_pkg::NUM_MAG_W-1:0] num_mag;
  logic [swc_pkg::DEN_W-1:0]     den_mag;
  logic                          neg;
  logic [swc_pkg::DEN_W-1:0]     rem_q [LAST];
  logic [swc_pkg::DEN_W-1:0]     den_q [LAST];
  logic [swc_pkg::NUM_MAG_W-1:0] nq_q  [swc_pkg::NUM_MAG_W];
  logic                          neg_q [swc_pkg::NUM_MAG_W];
  logic signed [swc_pkg::NUM_W-1:0] quo_q;

  assign num_mag = num_i[swc_pkg::NUM_W-1] ? swc_pkg::NUM_MAG_W'(-num_i)
                                           : swc_pkg::NUM_MAG_W'(num_i);
  assign den_mag = den_i[swc_pkg::DEN_W] ? swc_pkg::DEN_W'(-den_i) : swc_pkg::DEN_W'(den_i);
  assign neg     = num_i[swc_pkg::NUM_W-1] ^ den_i[swc_pkg::DEN_W];

  for (genvar k = 0; k < swc_pkg::NUM_MAG_W; k++) begin : g_stage
    logic [swc_pkg::DEN_W-1:0]     rem_in, den_in;
    logic [swc_pkg::NUM_MAG_W-1:0] nq_in;
    logic                          neg_in, take;
    logic [swc_pkg::DEN_W:0]       trial;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_mag;
      assign nq_in  = num_mag;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign trial = {rem_in, nq_in[swc_pkg::NUM_MAG_W-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[swc_pkg::NUM_MAG_W-2:0], take};
        neg_q[k] <= neg_in;
      end
    end

    if (k < LAST) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? swc_pkg::DEN_W'(trial - {1'b0, den_in})
                           : trial[swc_pkg::DEN_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[LAST] ? -$signed({1'b0, nq_q[LAST]}) : $signed({1'b0, nq_q[LAST]});
    end
  end

  assign quo_o = quo_q;

endmodule

[rtl/swc_back.sv]
// ----------------------------------------------------------------------------
// swc_back
// Execution pipeline: assay values, numerators, three dividers, the final
// scale by product quantity, saturation and the output register.
// ----------------------------------------------------------------------------
module swc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  swc_pkg::item_t                      q_item_i,
  output logic                                q_pop_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic signed [swc_pkg::RES_W-1:0]    feed_mass_o,
  output logic signed [swc_pkg::RES_W-1:0]    tails_mass_o,
  output logic signed [swc_pkg::RES_W-1:0]    sep_work_o,
  output swc_pkg::err_e                       err_o
);

  localparam int S7 = swc_pkg::VALUE_LAT + 1;
  localparam int SQ = swc_pkg::DIV_OUT_STG;

  logic                             adv;
  logic [swc_pkg::PIPE_LAST:0]      vld_q;
  swc_pkg::ctx_t                    ctx_q [swc_pkg::PIPE_LAST];
  logic signed [swc_pkg::V_W-1:0]   vf, vp, vt;
  logic signed [swc_pkg::DEN_W:0]   dpt, dpf, den_w;
  logic signed [swc_pkg::NUM_W-1:0] mf_q, mt_q, ma_q, mb_q;
  logic signed [swc_pkg::NUM_W-1:0] nf_q, nt_q, ns_q;
  logic signed [swc_pkg::DEN_W:0]   den_q;
  logic signed [swc_pkg::NUM_W-1:0] qf, qt, qs, s_w;
  logic signed [swc_pkg::RES_W-1:0] fm1_q, tm1_q, fm2_q, tm2_q;
  logic                             sneg1_q, sneg2_q;
  logic [swc_pkg::NUM_MAG_W-1:0]    smag_q;
  logic [swc_pkg::PP0_W-1:0]        pp0_q;
  logic [swc_pkg::PP1_W-1:0]        pp1_q;
  logic [swc_pkg::PROD_W-1:0]       prod;
  logic [swc_pkg::SH_W-1:0]         res;
  logic signed [swc_pkg::RES_W-1:0] sw;
  logic signed [swc_pkg::RES_W-1:0] fm_q, tm_q, sw_q;
  swc_pkg::err_e                    err_q;

  assign adv     = !vld_q[swc_pkg::PIPE_LAST] || m_tready_i;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[swc_pkg::PIPE_LAST-1:0], q_valid_i};
    end
  end

  for (genvar k = 0; k < swc_pkg::PIPE_LAST; k++) begin : g_ctx
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ctx_q[k].item <= q_item_i;
          ctx_q[k].vp   <= '0;
        end
      end
    end else if (k == S7) begin : g_vp
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ctx_q[k].item <= ctx_q[k-1].item;
          ctx_q[k].vp   <= vp;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ctx_q[k] <= ctx_q[k-1];
        end
      end
    end
  end

  swc_value u_value_f (.clk_i, .en_i(adv), .x_i(ctx_q[0].item.feed_assay),    .v_o(vf));
  swc_value u_value_p (.clk_i, .en_i(adv), .x_i(ctx_q[0].item.product_assay), .v_o(vp));
  swc_value u_value_t (.clk_i, .en_i(adv), .x_i(ctx_q[0].item.tails_assay),   .v_o(vt));

  assign dpt   = $signed({1'b0, ctx_q[S7-1].item.product_assay})
               - $signed({1'b0, ctx_q[S7-1].item.tails_assay});
  assign dpf   = $signed({1'b0, ctx_q[S7-1].item.product_assay})
               - $signed({1'b0, ctx_q[S7-1].item.feed_assay});
  assign den_w = $signed({1'b0, ctx_q[S7].item.feed_assay})
               - $signed({1'b0, ctx_q[S7].item.tails_assay});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mf_q  <= $signed({1'b0, ctx_q[S7-1].item.product_mass}) * dpt;
      mt_q  <= $signed({1'b0, ctx_q[S7-1].item.product_mass}) * dpf;
      ma_q  <= dpf * vt;
      mb_q  <= dpt * vf;
      nf_q  <= mf_q;
      nt_q  <= mt_q;
      ns_q  <= ma_q - mb_q;
      den_q <= den_w;
    end
  end

  swc_div u_div_f (.clk_i, .en_i(adv), .num_i(nf_q), .den_i(den_q), .quo_o(qf));
  swc_div u_div_t (.clk_i, .en_i(adv), .num_i(nt_q), .den_i(den_q), .quo_o(qt));
  swc_div u_div_s (.clk_i, .en_i(adv), .num_i(ns_q), .den_i(den_q), .quo_o(qs));

  assign s_w  = swc_pkg::NUM_W'(ctx_q[SQ].vp) + qs;
  assign prod = {pp1_q, {swc_pkg::LO_W{1'b0}}} + swc_pkg::PROD_W'(pp0_q);
  assign res  = prod[swc_pkg::PROD_W-1:swc_pkg::FRAC_Q];

  always_comb begin
    if (!sneg2_q) begin
      sw = (res > swc_pkg::SH_W'(swc_pkg::RES_MAX)) ? swc_pkg::RES_MAX : res[swc_pkg::RES_W-1:0];
    end else begin
      sw = (res > swc_pkg::SH_W'(swc_pkg::RES_MAX) + swc_pkg::SH_W'(1)) ? swc_pkg::RES_MIN
                                                                        : -res[swc_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fm1_q   <= swc_pkg::sat48(qf);
      tm1_q   <= swc_pkg::sat48(qt);
      sneg1_q <= s_w[swc_pkg::NUM_W-1];
      smag_q  <= s_w[swc_pkg::NUM_W-1] ? swc_pkg::NUM_MAG_W'(-s_w) : swc_pkg::NUM_MAG_W'(s_w);
      fm2_q   <= fm1_q;
      tm2_q   <= tm1_q;
      sneg2_q <= sneg1_q;
      pp0_q   <= smag_q[swc_pkg::LO_W-1:0] * ctx_q[SQ+1].item.product_mass;
      pp1_q   <= smag_q[swc_pkg::NUM_MAG_W-1:swc_pkg::LO_W] * ctx_q[SQ+1].item.product_mass;
      err_q   <= ctx_q[swc_pkg::PIPE_LAST-1].item.err;
      if (ctx_q[swc_pkg::PIPE_LAST-1].item.err != swc_pkg::ERR_OK) begin
        fm_q <= '0;
        tm_q <= '0;
        sw_q <= '0;
      end else begin
        fm_q <= fm2_q;
        tm_q <= tm2_q;
        sw_q <= sw;
      end
    end
  end

  assign m_tvalid_o   = vld_q[swc_pkg::PIPE_LAST];
  assign feed_mass_o  = fm_q;
  assign tails_mass_o = tm_q;
  assign sep_work_o   = sw_q;
  assign err_o        = err_q;

endmodule

[rtl/swc_checker.sv]
// ----------------------------------------------------------------------------
// swc_assert
// Port-level checks for the separative work calculator, bound to the top.
// ----------------------------------------------------------------------------
module swc_assert (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [swc_pkg::DATA_OUT_W-1:0]  m_axis_tdata_o,
  input logic [1:0]                      m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != swc_pkg::ERR_OK |-> m_axis_tdata_o == '0)
    else $error("flagged word carries nonzero data");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |=> s_axis_tready_o)
    else $error("input stalled while output idle");

endmodule

bind separative_work_calculator_top swc_assert u_assert (.*);

[dv/swc_checker.sv]
// ----------------------------------------------------------------------------
// swc_checker
// Watches both stream channels of the separative work calculator, predicts
// feed mass, tails mass, separative work and error code for every accepted
// input word, and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module swc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [swc_pkg::DATA_IN_W-1:0]  s_axis_tdata_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [swc_pkg::DATA_OUT_W-1:0] m_axis_tdata_i,
  input  logic [1:0]                     m_axis_tuser_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [swc_pkg::RES_W-1:0] feed;
    logic [swc_pkg::RES_W-1:0] tails;
    logic [swc_pkg::RES_W-1:0] work;
    swc_pkg::err_e             err;
  } swu_t;

  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;

  longint unsigned log2_frac [swc_pkg::TBL_N];
  swu_t            swu_q [$];
  int              fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = swu_q.size();

  initial begin
    longint unsigned y;
    longint unsigned v;
    for (int i = 0; i < swc_pkg::TBL_N - 1; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - swc_pkg::LOG_TABLE_BITS));
      v = 0;
      for (int k = 0; k < 28; k++) begin
        y = (y * y) >> 30;
        v = v << 1;
        if (y >= (64'd1 << 31)) begin
          v = v | 1;
          y = y >> 1;
        end
      end
      log2_frac[i] = v;
    end
    log2_frac[swc_pkg::TBL_N-1] = 64'd1 << 28;
  end

  function automatic longint floor_div_pow2(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
  endfunction

  function automatic longint log2_fixed(longint unsigned n);
    int              e;
    longint unsigned m, f, r, lo, hi, d;
    int              idx;
    e = 0;
    if (n == 0) n = 1;
    while ((n >> e) > 1) e++;
    m = n << (31 - e);
    f = m - (64'd1 << 31);
    idx = int'((f >> (31 - swc_pkg::LOG_TABLE_BITS)) & ((1 << swc_pkg::LOG_TABLE_BITS) - 1));
    r = f & ((64'd1 << (31 - swc_pkg::LOG_TABLE_BITS)) - 1);
    lo = log2_frac[idx];
    hi = log2_frac[idx + 1];
    d = hi > lo ? hi - lo : 0;
    return (longint'(e) << 28) + longint'(lo + ((d * r) >> (31 - swc_pkg::LOG_TABLE_BITS)));
  endfunction

  function automatic longint assay_value(longint x);
    longint dl, ln, w;
    dl = log2_fixed(64'(16777216 - x)) - log2_fixed(64'(x));
    ln = floor_div_pow2(dl * 64'sd186065279, 28);
    w  = 64'sd16777216 - 2 * x;
    return floor_div_pow2(w * ln, 24);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  function automatic longint scale_work(longint unsigned p, longint s);
    logic              neg;
    logic [127:0]      prod;
    logic [127:0]      res;
    longint unsigned   mag;
    neg  = s < 0;
    mag  = neg ? 64'd0 - 64'(s) : 64'(s);
    prod = 128'(mag) * 128'(p);
    res  = prod >> 28;
    if (!neg) return res > 128'(MAX48) ? MAX48 : longint'(res[63:0]);
    return res > 128'(MAX48) + 1 ? MIN48 : -longint'(res[63:0]);
  endfunction

  function automatic swu_t predict_swu(logic [swc_pkg::DATA_IN_W-1:0] w);
    swu_t   o;
    longint p, xf, xp, xt, d, vf, vp, vt, s;
    p  = longint'(w[31:0]);
    xf = longint'(w[55:32]);
    xp = longint'(w[79:56]);
    xt = longint'(w[103:80]);
    o.feed = '0;
    o.tails = '0;
    o.work = '0;
    o.err = swc_pkg::ERR_OK;
    if (xf == 0 || xp == 0 || xt == 0) o.err = swc_pkg::ERR_ZERO_ASSAY;
    else if (xf == xt) o.err = swc_pkg::ERR_FEED_TAILS;
    else begin
      d  = xf - xt;
      vf = assay_value(xf);
      vp = assay_value(xp);
      vt = assay_value(xt);
      o.feed  = swc_pkg::RES_W'(clamp48((p * (xp - xt)) / d));
      o.tails = swc_pkg::RES_W'(clamp48((p * (xp - xf)) / d));
      s = vp + ((xp - xf) * vt - (xp - xt) * vf) / d;
      o.work  = swc_pkg::RES_W'(scale_work(64'(p), s));
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    swu_t exp_swu;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) swu_q.push_back(predict_swu(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (swu_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word %h", m_axis_tdata_i);
          fail_count <= fail_count + 1;
        end else begin
          exp_swu = swu_q.pop_front();
          if (m_axis_tdata_i[47:0] !== exp_swu.feed || m_axis_tdata_i[95:48] !== exp_swu.tails
              || m_axis_tdata_i[143:96] !== exp_swu.work || m_axis_tuser_i !== exp_swu.err) begin
            if (fail_count < 10)
              $display("mismatch: exp feed %h tails %h work %h err %0d, got %h %h %h %0d",
                       exp_swu.feed, exp_swu.tails, exp_swu.work, exp_swu.err,
                       m_axis_tdata_i[47:0], m_axis_tdata_i[95:48], m_axis_tdata_i[143:96],
                       m_axis_tuser_i);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb_separative_work_calculator_top.sv]
// ----------------------------------------------------------------------------
// tb_separative_work_calculator_top
// Drives directed corner words and random assay sets through the
// calculator under several idle and stall phases and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_separative_work_calculator_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [swc_pkg::DATA_IN_W-1:0]  s_axis_tdata_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [swc_pkg::DATA_OUT_W-1:0] m_axis_tdata_o;
  logic [1:0]                     m_axis_tuser_o;
  int                             fail_count, pending;
  int                             send_idle_pct = 0, recv_stall_pct = 0;
  bit                             hold_off = 1'b0;
  bit                             done = 1'b0;
  longint                         cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  separative_work_calculator_top uut (.*);

  swc_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000 && !done) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] q, logic [23:0] f, logic [23:0] p, logic [23:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {t, p, f, q};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_assay();
    case ($urandom_range(7))
      0: return 24'($urandom_range(15));
      1: return 24'hFFFFFF - 24'($urandom_range(15));
      2: return 24'($urandom_range(200000));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] f, p, t;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_word(32'd2560, 24'd0, 24'd100, 24'd50);
    send_word(32'd2560, 24'd100, 24'd0, 24'd50);
    send_word(32'd2560, 24'd100, 24'd100, 24'd0);
    send_word(32'd2560, 24'd1000, 24'd5000, 24'd1000);
    send_word(32'hFFFFFFFF, 24'd1, 24'hFFFFFF, 24'd2);
    send_word(32'hFFFFFFFF, 24'd2, 24'hFFFFFF, 24'd1);
    send_word(32'hFFFFFFFF, 24'hFFFFFF, 24'd1, 24'hFFFFFE);
    send_word(32'd0, 24'd119000, 24'd838000, 24'd42000);
    send_word(32'd256, 24'd119000, 24'd838000, 24'd42000);
    send_word(32'h12345678, 24'd119000, 24'd838000, 24'd42000);
    send_word(32'd1, 24'h800000, 24'h800000, 24'd1);
    send_word(32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(32'hFFFFFFFF, 24'hAAAAAA, 24'h555555, 24'h000001);
    send_word(32'hAAAAAAAA, 24'h555555, 24'hAAAAAA, 24'hFFFFFE);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      for (int i = 0; i < 208; i++) begin
        f = rand_assay();
        p = rand_assay();
        t = $urandom_range(9) == 0 ? f : rand_assay();
        send_word($urandom_range(3) == 0 ? 32'($urandom_range(65535)) : 32'($urandom),
                  f, p, t);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0 || hold_off) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    done = 1'b1;
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
